>>> src/sobel_edge_magnitude_macros.svh
// Assertion helpers for the edge magnitude block.
// Both macros expect signals named clk and rst_n in the module that uses them.
`ifndef SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define SEM_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sobel edge magnitude: same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define SEM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sobel edge magnitude: next-cycle check failed");
`else
`define SEM_ASSERT_IMPLY(label, ante, cons)
`define SEM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/sem_pkg.sv
`default_nettype none

package sem_pkg;

    // Sizes and reset values.
    localparam int SEM_MAX_WIDTH   = 1024;
    localparam int WIDTH_BITS      = 11;
    localparam int HEIGHT_BITS     = 16;
    localparam int PIX_BITS        = 8;
    localparam int CFG_DATA_BITS   = 16;
    localparam int CFG_INDEX_BITS  = 1;
    localparam int CMD_QUEUE_DEPTH = 4;
    localparam int RES_QUEUE_DEPTH = 2;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;

    // Register indexes of the configuration port.
    localparam cfg_index_t REG_IMAGE_WIDTH  = 1'b0;
    localparam cfg_index_t REG_IMAGE_HEIGHT = 1'b1;

    // Request operation codes.
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [PIX_BITS-1:0] MAG_SATURATED = 8'd255;

    typedef logic [PIX_BITS-1:0] pixel_t;
    typedef logic signed [10:0]  grad_t;

    // Window layout: rows top, middle, bottom; within a row left, centre, right.
    typedef pixel_t [8:0] window_t;

    // Classification of one accepted request, passed from front to back.
    typedef struct packed {
        logic drain;      // drain request rather than a pixel
        logic first_row;  // pixel of the first row of the frame
        logic emit_main;  // pixel produces the result for the previous column
        logic emit_edge;  // pixel closes a row and produces the final column
        logic tail;       // pixel ends a row, or drain request is the last one
    } cmd_flags_t;

    typedef struct packed {
        logic [PIX_BITS-1:0] magnitude;
        logic                last_in_run;
        logic                end_of_frame;
    } result_t;

    // Horizontal gradient. At the right edge the window is read one column
    // further right, with the right column replicated.
    function automatic grad_t sobel_gx(input window_t win, input logic right_edge);
        logic signed [11:0] tl;
        logic signed [11:0] tr;
        logic signed [11:0] ml;
        logic signed [11:0] mr;
        logic signed [11:0] bl;
        logic signed [11:0] br;
        logic signed [11:0] s;
        tl = $signed({4'b0000, (right_edge ? win[1] : win[0])});
        tr = $signed({4'b0000, win[2]});
        ml = $signed({4'b0000, (right_edge ? win[4] : win[3])});
        mr = $signed({4'b0000, win[5]});
        bl = $signed({4'b0000, (right_edge ? win[7] : win[6])});
        br = $signed({4'b0000, win[8]});
        s  = (tr - tl) + ((mr - ml) <<< 1) + (br - bl);
        return grad_t'(s[10:0]);
    endfunction

    // Vertical gradient, top row minus bottom row.
    function automatic grad_t sobel_gy(input window_t win, input logic right_edge);
        logic signed [11:0] tl;
        logic signed [11:0] tc;
        logic signed [11:0] tr;
        logic signed [11:0] bl;
        logic signed [11:0] bc;
        logic signed [11:0] br;
        logic signed [11:0] s;
        tl = $signed({4'b0000, (right_edge ? win[1] : win[0])});
        tc = $signed({4'b0000, (right_edge ? win[2] : win[1])});
        tr = $signed({4'b0000, win[2]});
        bl = $signed({4'b0000, (right_edge ? win[7] : win[6])});
        bc = $signed({4'b0000, (right_edge ? win[8] : win[7])});
        br = $signed({4'b0000, win[8]});
        s  = (tl + (tc <<< 1) + tr) - (bl + (bc <<< 1) + br);
        return grad_t'(s[10:0]);
    endfunction

endpackage

`default_nettype wire

>>> src/sobel_edge_magnitude.sv
// Sobel 3x3 gradient magnitude over a raster stream of 8-bit pixels, with the
// border pixels replicated on all four sides. Pixels go in through a queue-like
// port (push/full) and magnitudes come out through another (empty/pop); the
// result for column x-1 of row y-1 appears after pixel (x,y), the last pixel of
// each row also yields that row's final column, and after the frame one drain
// request (op = 1) per column yields the bottom row, with end_of_frame on the
// last one. Requests that do not fit the current phase are taken and dropped.
// Up to four classified requests wait between the front end and the execution
// unit. The execution unit handles one request at a time: it reads and updates
// the line stores, then for each result computes the gradients, makes two
// passes through one shared squarer, runs an eight-step bit-serial square root
// and hands the result off; a drain request reads its three columns in turn
// through the single read port of each line store. The line stores need no
// clearing after reset. The configuration registers should only be written
// while no results are pending.
`default_nettype none

module sobel_edge_magnitude #(
    parameter int MAX_WIDTH = sem_pkg::SEM_MAX_WIDTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire sem_pkg::cfg_index_t               cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
    input  wire logic                              push,
    output logic                                   full,
    input  wire logic                              op,
    input  wire sem_pkg::pixel_t                   pixel,
    output logic                                   empty,
    input  wire logic                              pop,
    output sem_pkg::pixel_t                        magnitude,
    output logic                                   last_in_run,
    output logic                                   end_of_frame
);

    import sem_pkg::*;

    localparam int AW       = $clog2(MAX_WIDTH);
    localparam int CMD_BITS = $bits(cmd_flags_t) + PIX_BITS + AW;
    localparam int RES_BITS = $bits(result_t);

    logic                cmd_full;
    logic                cmd_empty;
    logic                cmd_push;
    logic                cmd_pop;
    cmd_flags_t          front_flags;
    pixel_t              front_pixel;
    logic [AW-1:0]       front_col;
    cmd_flags_t          back_flags;
    pixel_t              back_pixel;
    logic [AW-1:0]       back_col;
    logic [CMD_BITS-1:0] cmd_wr;
    logic [CMD_BITS-1:0] cmd_rd;

    logic                res_full;
    logic                res_push;
    result_t             res_in;
    result_t             res_out;
    logic [RES_BITS-1:0] res_rd;

    // Front end: configuration, raster position and classification.
    sem_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .op        (op),
        .pixel     (pixel),
        .cmd_full  (cmd_full),
        .cmd_push  (cmd_push),
        .cmd_flags (front_flags),
        .cmd_pixel (front_pixel),
        .cmd_col   (front_col)
    );

    assign full   = cmd_full;
    assign cmd_wr = {front_flags, front_pixel, front_col};
    assign {back_flags, back_pixel, back_col} = cmd_rd;

    // Request queue between front and back.
    sem_fifo #(
        .WIDTH (CMD_BITS),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (cmd_push),
        .wr_data (cmd_wr),
        .full    (cmd_full),
        .pop     (cmd_pop),
        .rd_data (cmd_rd),
        .empty   (cmd_empty)
    );

    // Back end: line stores, window and magnitude.
    sem_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd_flags (back_flags),
        .cmd_pixel (back_pixel),
        .cmd_col   (back_col),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_in)
    );

    // Result queue towards the consumer.
    sem_fifo #(
        .WIDTH (RES_BITS),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .pop     (pop),
        .rd_data (res_rd),
        .empty   (empty)
    );

    assign res_out      = res_rd;
    assign magnitude    = res_out.magnitude;
    assign last_in_run  = res_out.last_in_run;
    assign end_of_frame = res_out.end_of_frame;

endmodule

`default_nettype wire

>>> src/sem_fifo.sv
`default_nettype none

module sem_fifo #(
    parameter int WIDTH = sem_pkg::PIX_BITS,
    parameter int DEPTH = sem_pkg::CMD_QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      rd_data,
    output logic                  empty
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CNTW-1:0]  count_reg;
    logic [CNTW-1:0]  count_next;
    logic             push_ok;
    logic             pop_ok;

    // Status and handshake qualification.
    assign full    = (count_reg == CNTW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign rd_data = mem[rd_ptr_reg];

    // Pointer wrap and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + CNTW'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - CNTW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> src/sem_front.sv
`default_nettype none
`include "sobel_edge_magnitude_macros.svh"

module sem_front #(
    parameter int MAX_WIDTH = sem_pkg::SEM_MAX_WIDTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire sem_pkg::cfg_index_t                cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire logic                               push,
    input  wire logic                               op,
    input  wire sem_pkg::pixel_t                    pixel,
    input  wire logic                               cmd_full,
    output logic                                    cmd_push,
    output sem_pkg::cmd_flags_t                     cmd_flags,
    output sem_pkg::pixel_t                         cmd_pixel,
    output logic [$clog2(MAX_WIDTH)-1:0]            cmd_col
);

    import sem_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = ((AW > WIDTH_BITS) ? AW : WIDTH_BITS) + 1;

    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    logic [AW-1:0]          col_reg;
    logic [AW-1:0]          col_next;
    logic [HEIGHT_BITS-1:0] row_reg;
    logic [HEIGHT_BITS-1:0] row_next;
    logic [AW-1:0]          drain_reg;
    logic [AW-1:0]          drain_next;
    logic                   phase_drain_reg;
    logic                   phase_drain_next;

    logic [CW-1:0]          width_nz;
    logic [CW-1:0]          width_act;
    logic [CW-1:0]          col_x_ext;
    logic [CW-1:0]          drain_d_ext;
    logic [AW-1:0]          col_x;
    logic [AW-1:0]          drain_d;
    logic [HEIGHT_BITS:0]   height_act;
    logic [HEIGHT_BITS:0]   row_inc;
    logic                   row_end;
    logic                   last_row;
    logic                   drain_last;
    logic                   accept;
    logic                   take_pixel;
    logic                   take_drain;

    // Width and height in use, with out-of-range values clamped.
    always_comb
    begin
        width_nz   = (width_reg == '0) ? CW'(1) : CW'(width_reg);
        width_act  = (width_nz > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : width_nz;
        height_act = (height_reg == '0) ? (HEIGHT_BITS + 1)'(1) : {1'b0, height_reg};
    end

    // Current column and drain position, clamped to the row width.
    always_comb
    begin
        col_x_ext   = (CW'(col_reg) >= width_act) ? width_act - CW'(1) : CW'(col_reg);
        drain_d_ext = (CW'(drain_reg) >= width_act) ? width_act - CW'(1) : CW'(drain_reg);
        col_x       = col_x_ext[AW-1:0];
        drain_d     = drain_d_ext[AW-1:0];
        row_end     = (col_x_ext + CW'(1)) >= width_act;
        drain_last  = (drain_d_ext + CW'(1)) >= width_act;
        row_inc     = {1'b0, row_reg} + (HEIGHT_BITS + 1)'(1);
        last_row    = row_inc >= height_act;
    end

    // Requests that do not fit the current phase are taken and dropped.
    assign accept     = push && !cmd_full;
    assign take_pixel = accept && (op == OP_PIXEL) && !phase_drain_reg;
    assign take_drain = accept && (op == OP_DRAIN) && phase_drain_reg;

    // Classification handed to the back end.
    always_comb
    begin
        cmd_push            = take_pixel || take_drain;
        cmd_flags.drain     = phase_drain_reg;
        cmd_flags.first_row = (row_reg == '0);
        cmd_flags.emit_main = (row_reg != '0) && (col_x != '0);
        cmd_flags.emit_edge = (row_reg != '0) && row_end;
        cmd_flags.tail      = phase_drain_reg ? drain_last : row_end;
        cmd_pixel           = pixel;
        cmd_col             = phase_drain_reg ? drain_d : col_x;
    end

    // Raster position and frame phase.
    always_comb
    begin
        col_next         = col_reg;
        row_next         = row_reg;
        drain_next       = drain_reg;
        phase_drain_next = phase_drain_reg;
        if (take_pixel)
        begin
            if (row_end)
            begin
                col_next = '0;
                if (last_row)
                begin
                    row_next         = '0;
                    drain_next       = '0;
                    phase_drain_next = 1'b1;
                end
                else
                begin
                    row_next = row_inc[HEIGHT_BITS-1:0];
                end
            end
            else
            begin
                col_next = AW'(col_x_ext + CW'(1));
            end
        end
        else if (take_drain)
        begin
            if (drain_last)
            begin
                drain_next       = '0;
                phase_drain_next = 1'b0;
            end
            else
            begin
                drain_next = AW'(drain_d_ext + CW'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg         <= '0;
            row_reg         <= '0;
            drain_reg       <= '0;
            phase_drain_reg <= 1'b0;
        end
        else
        begin
            col_reg         <= col_next;
            row_reg         <= row_next;
            drain_reg       <= drain_next;
            phase_drain_reg <= phase_drain_next;
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata[HEIGHT_BITS-1:0];
                default:          ;
            endcase
        end
    end

    // The last pixel of the last row switches to draining, and the last
    // drain request returns to pixels at column zero.
    `SEM_ASSERT_NEXT(a_frame_end_drains, take_pixel && row_end && last_row, phase_drain_reg)
    `SEM_ASSERT_NEXT(a_drain_end_receives, take_drain && drain_last, !phase_drain_reg && drain_reg == '0)

endmodule

`default_nettype wire

>>> src/sem_back.sv
`default_nettype none
`include "sobel_edge_magnitude_macros.svh"

module sem_back #(
    parameter int MAX_WIDTH = sem_pkg::SEM_MAX_WIDTH
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cmd_empty,
    output logic                              cmd_pop,
    input  wire sem_pkg::cmd_flags_t          cmd_flags,
    input  wire sem_pkg::pixel_t              cmd_pixel,
    input  wire logic [$clog2(MAX_WIDTH)-1:0] cmd_col,
    input  wire logic                         res_full,
    output logic                              res_push,
    output sem_pkg::result_t                  res_data
);

    import sem_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_READ = 8'b0000_0010,
        S_LOAD = 8'b0000_0100,
        S_GRAD = 8'b0000_1000,
        S_SQX  = 8'b0001_0000,
        S_SQY  = 8'b0010_0000,
        S_ROOT = 8'b0100_0000,
        S_PUSH = 8'b1000_0000
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [1:0]         step_reg;
    logic [1:0]         step_next;
    logic               second_reg;
    logic               second_next;

    cmd_flags_t         flags_reg;
    pixel_t             pixel_reg;
    logic [AW-1:0]      col_reg;
    window_t            win_reg;
    grad_t              gx_reg;
    grad_t              gy_reg;
    logic [19:0]        sq_reg;
    logic [20:0]        sum_reg;
    logic [7:0]         root_reg;
    logic [7:0]         bit_reg;

    pixel_t             upper_mem [MAX_WIDTH];
    pixel_t             middle_mem [MAX_WIDTH];
    pixel_t             upper_q;
    pixel_t             middle_q;

    logic [AW-1:0]      rd_addr;
    logic               mem_we;
    pixel_t             top_v;
    pixel_t             mid_v;
    pixel_t             col_v [3];
    grad_t              mul_op;
    logic signed [21:0] prod;
    logic [7:0]         trial;
    logic [15:0]        trial_sq;
    logic [15:0]        root_sq;
    logic               sat;
    logic               root_done;

    // Line store address: the pixel's column, or the three drain columns in turn.
    always_comb
    begin
        rd_addr = col_reg;
        if (flags_reg.drain)
        begin
            case (step_reg)
                2'd0:    rd_addr = (col_reg == '0) ? '0 : col_reg - AW'(1);
                2'd1:    rd_addr = col_reg;
                default: rd_addr = flags_reg.tail ? col_reg : col_reg + AW'(1);
            endcase
        end
    end

    // On the first row both line stores take the incoming pixel.
    always_comb
    begin
        mem_we   = (state_reg == S_LOAD) && !flags_reg.drain;
        top_v    = flags_reg.first_row ? pixel_reg : upper_q;
        mid_v    = flags_reg.first_row ? pixel_reg : middle_q;
        col_v[0] = top_v;
        col_v[1] = mid_v;
        col_v[2] = pixel_reg;
    end

    // Line stores with registered read data.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
        begin
            upper_q  <= upper_mem[rd_addr];
            middle_q <= middle_mem[rd_addr];
        end
        if (mem_we)
        begin
            upper_mem[col_reg]  <= mid_v;
            middle_mem[col_reg] <= pixel_reg;
        end
    end

    // One shared squarer and the bit-serial root trial.
    always_comb
    begin
        mul_op    = (state_reg == S_SQX) ? gx_reg : gy_reg;
        prod      = 22'(mul_op) * 22'(mul_op);
        trial     = root_reg | bit_reg;
        trial_sq  = 16'(trial) * 16'(trial);
        root_sq   = 16'(root_reg) * 16'(root_reg);
        sat       = (sum_reg[20:16] != '0);
        root_done = sat || bit_reg[0];
    end

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        second_next = second_reg;
        cmd_pop     = 1'b0;
        res_push    = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop    = 1'b1;
                    step_next  = 2'd0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (flags_reg.drain)
                begin
                    second_next = 1'b0;
                    if (step_reg != 2'd2)
                    begin
                        step_next  = step_reg + 2'd1;
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_GRAD;
                    end
                end
                else if (flags_reg.emit_main || flags_reg.emit_edge)
                begin
                    second_next = !flags_reg.emit_main;
                    state_next  = S_GRAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_GRAD:
            begin
                state_next = S_SQX;
            end
            S_SQX:
            begin
                state_next = S_SQY;
            end
            S_SQY:
            begin
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                if (root_done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (!flags_reg.drain && !second_reg && flags_reg.emit_edge)
                    begin
                        second_next = 1'b1;
                        state_next  = S_GRAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            step_reg   <= 2'd0;
            second_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            step_reg   <= step_next;
            second_reg <= second_next;
        end
    end

    // Datapath: request capture, window, gradients, squares and root.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_pop)
                begin
                    flags_reg <= cmd_flags;
                    pixel_reg <= cmd_pixel;
                    col_reg   <= cmd_col;
                end
            end
            S_LOAD:
            begin
                if (flags_reg.drain)
                begin
                    // The bottom row repeats the middle row below the image.
                    case (step_reg)
                        2'd0:
                        begin
                            win_reg[0] <= upper_q;
                            win_reg[3] <= middle_q;
                            win_reg[6] <= middle_q;
                        end
                        2'd1:
                        begin
                            win_reg[1] <= upper_q;
                            win_reg[4] <= middle_q;
                            win_reg[7] <= middle_q;
                        end
                        default:
                        begin
                            win_reg[2] <= upper_q;
                            win_reg[5] <= middle_q;
                            win_reg[8] <= middle_q;
                        end
                    endcase
                end
                else
                begin
                    // Shift the window left; column zero replicates the left edge.
                    for (int r = 0; r < 3; r++)
                    begin
                        if (col_reg == '0)
                        begin
                            win_reg[r * 3]     <= col_v[r];
                            win_reg[r * 3 + 1] <= col_v[r];
                        end
                        else
                        begin
                            win_reg[r * 3]     <= win_reg[r * 3 + 1];
                            win_reg[r * 3 + 1] <= win_reg[r * 3 + 2];
                        end
                        win_reg[r * 3 + 2] <= col_v[r];
                    end
                end
            end
            S_GRAD:
            begin
                gx_reg <= sobel_gx(win_reg, second_reg);
                gy_reg <= sobel_gy(win_reg, second_reg);
            end
            S_SQX:
            begin
                sq_reg <= prod[19:0];
            end
            S_SQY:
            begin
                sum_reg  <= {1'b0, sq_reg} + {1'b0, prod[19:0]};
                root_reg <= '0;
                bit_reg  <= 8'h80;
            end
            S_ROOT:
            begin
                if (sat)
                begin
                    root_reg <= MAG_SATURATED;
                end
                else
                begin
                    if (trial_sq <= sum_reg[15:0])
                    begin
                        root_reg <= trial;
                    end
                    bit_reg <= bit_reg >> 1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Result fields.
    always_comb
    begin
        res_data.magnitude    = root_reg;
        res_data.last_in_run  = flags_reg.drain || second_reg || !flags_reg.emit_edge;
        res_data.end_of_frame = flags_reg.drain && flags_reg.tail;
    end

    `SEM_ASSERT_NEXT(a_pop_starts_read, cmd_pop, state_reg == S_READ)
    `SEM_ASSERT_IMPLY(a_root_bound, state_reg == S_ROOT && !sat, root_sq <= sum_reg[15:0])
    `SEM_ASSERT_IMPLY(a_edge_result_source, res_push && second_reg, !flags_reg.drain && flags_reg.emit_edge)

endmodule

`default_nettype wire

>>> bench/tb_sobel_edge_magnitude.sv
`timescale 1ns / 1ps

module tb_sobel_edge_magnitude;
    import sem_pkg::*;

    // Long enough for every queued request without a result to pass through.
    localparam int SETTLE_CYCLES    = 300;
    localparam int CYCLE_LIMIT      = 2000000;
    localparam int SHOWN_MISMATCHES = 100;

    typedef enum bit {RECEIVING, DRAINING} frame_state_t;
    typedef enum int {NOISE_TEXTURE, HARD_EDGES, SMOOTH_TEXTURE} texture_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    cfg_index_t               cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     push      = 1'b0;
    logic                     op        = OP_PIXEL;
    pixel_t                   pixel     = '0;
    logic                     pop       = 1'b0;
    logic                     full;
    logic                     empty;
    pixel_t                   magnitude;
    logic                     last_in_run;
    logic                     end_of_frame;

    sobel_edge_magnitude DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .push         (push),
        .full         (full),
        .op           (op),
        .pixel        (pixel),
        .empty        (empty),
        .pop          (pop),
        .magnitude    (magnitude),
        .last_in_run  (last_in_run),
        .end_of_frame (end_of_frame)
    );

    // Our own copy of the block's registers, line stores and window.
    logic [WIDTH_BITS-1:0]  width_reg;
    logic [HEIGHT_BITS-1:0] height_reg;
    pixel_t                 upper_row [SEM_MAX_WIDTH];
    pixel_t                 middle_row [SEM_MAX_WIDTH];
    pixel_t                 window_reg [9];
    int unsigned            col_pos;
    int unsigned            row_pos;
    int unsigned            drain_col;
    frame_state_t           frame_state;

    result_t     expected_magnitudes [$];
    int          error_count   = 0;
    int          result_count  = 0;
    int unsigned cycle_count   = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic int unsigned active_columns();
        int unsigned w;
        w = width_reg;
        if (w == 0) w = 1;
        if (w > SEM_MAX_WIDTH) w = SEM_MAX_WIDTH;
        return w;
    endfunction

    function automatic int unsigned active_rows();
        return (height_reg == 0) ? 1 : height_reg;
    endfunction

    // Integer square root, bit by bit from the top, saturated to eight bits.
    function automatic pixel_t saturated_root(int unsigned s);
        int unsigned root;
        int unsigned trial;
        int unsigned probe;
        if (s >= 65536) return MAG_SATURATED;
        root = 0;
        for (probe = 128; probe != 0; probe = probe >> 1)
        begin
            trial = root | probe;
            if (trial * trial <= s) root = trial;
        end
        return pixel_t'(root);
    endfunction

    // Sobel magnitude; a, b and c select the left, centre and right column.
    function automatic pixel_t gradient_magnitude(pixel_t win [9], int a, int b, int c);
        int gx;
        int gy;
        gx = (int'(win[c]) - int'(win[a])) + 2 * (int'(win[3+c]) - int'(win[3+a]))
             + (int'(win[6+c]) - int'(win[6+a]));
        gy = (int'(win[a]) + 2 * int'(win[b]) + int'(win[c]))
             - (int'(win[6+a]) + 2 * int'(win[6+b]) + int'(win[6+c]));
        return saturated_root(gx * gx + gy * gy);
    endfunction

    function automatic void add_expected_result(pixel_t mag, bit last, bit eof);
        result_t r;
        r.magnitude    = mag;
        r.last_in_run  = last;
        r.end_of_frame = eof;
        expected_magnitudes.push_back(r);
    endfunction

    function automatic void reset_predictor();
        width_reg   = WIDTH_RESET;
        height_reg  = HEIGHT_RESET;
        for (int i = 0; i < SEM_MAX_WIDTH; i++)
        begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
        for (int i = 0; i < 9; i++) window_reg[i] = '0;
        col_pos     = 0;
        row_pos     = 0;
        drain_col   = 0;
        frame_state = RECEIVING;
    endfunction

    // Advances the tracked state by one accepted request and queues its results.
    function automatic void predict_request(bit op_code, pixel_t value);
        int unsigned w;
        int unsigned x;
        int unsigned d;
        int unsigned cl;
        int unsigned cr;
        int          r;
        pixel_t      top;
        pixel_t      mid;
        pixel_t      v;
        pixel_t      drain_win [9];
        bit          row_end;
        w = active_columns();
        if (op_code == OP_PIXEL)
        begin
            if (frame_state != RECEIVING) return;
            x = (col_pos >= w) ? w - 1 : col_pos;
            // The first row of a frame stands in for the rows above it.
            if (row_pos == 0)
            begin
                top = value;
                mid = value;
            end
            else
            begin
                top = upper_row[x];
                mid = middle_row[x];
            end
            upper_row[x]  = mid;
            middle_row[x] = value;
            // Shift the window left; column zero replicates the left border.
            for (r = 0; r < 3; r++)
            begin
                v = (r == 0) ? top : ((r == 1) ? mid : value);
                if (x == 0)
                begin
                    window_reg[3*r]   = v;
                    window_reg[3*r+1] = v;
                end
                else
                begin
                    window_reg[3*r]   = window_reg[3*r+1];
                    window_reg[3*r+1] = window_reg[3*r+2];
                end
                window_reg[3*r+2] = v;
            end
            row_end = (x + 1 >= w);
            if (row_pos >= 1)
            begin
                if (x >= 1) add_expected_result(gradient_magnitude(window_reg, 0, 1, 2),
                                                !row_end, 1'b0);
                if (row_end) add_expected_result(gradient_magnitude(window_reg, 1, 2, 2),
                                                 1'b1, 1'b0);
            end
            if (row_end)
            begin
                col_pos = 0;
                if (row_pos + 1 >= active_rows())
                begin
                    row_pos     = 0;
                    drain_col   = 0;
                    frame_state = DRAINING;
                end
                else
                begin
                    row_pos++;
                end
            end
            else
            begin
                col_pos = x + 1;
            end
        end
        else
        begin
            if (frame_state != DRAINING) return;
            // The bottom row replicates the middle line store below itself.
            d  = (drain_col >= w) ? w - 1 : drain_col;
            cl = (d == 0) ? 0 : d - 1;
            cr = (d + 1 < w) ? d + 1 : w - 1;
            drain_win[0] = upper_row[cl];
            drain_win[1] = upper_row[d];
            drain_win[2] = upper_row[cr];
            drain_win[3] = middle_row[cl];
            drain_win[4] = middle_row[d];
            drain_win[5] = middle_row[cr];
            drain_win[6] = drain_win[3];
            drain_win[7] = drain_win[4];
            drain_win[8] = drain_win[5];
            add_expected_result(gradient_magnitude(drain_win, 0, 1, 2), 1'b1, d + 1 >= w);
            if (d + 1 >= w)
            begin
                drain_col   = 0;
                frame_state = RECEIVING;
            end
            else
            begin
                drain_col = d + 1;
            end
        end
    endfunction

    function automatic pixel_t pick_pixel(texture_t texture);
        case (texture)
            NOISE_TEXTURE:  return pixel_t'($urandom);
            HARD_EDGES:     return $urandom_range(1) ? 8'hFF : 8'h00;
            default:        return pixel_t'($urandom_range(96, 127));
        endcase
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        if (error_count < SHOWN_MISMATCHES)
            $display("mismatch at result %0d: %s is %0d, expected %0d",
                     result_count, what, got, want);
        error_count++;
    endtask

    // Offers one request, with a random gap first, and holds it until taken.
    task automatic send_request(bit op_code, pixel_t value);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push  <= 1'b1;
        op    <= op_code;
        pixel <= value;
        do
            @(posedge clk);
        while (full);
        predict_request(op_code, value);
    endtask

    // Stops sending and waits until every expected result is out and the
    // requests that cause none have passed through as well.
    task automatic wait_idle();
        push <= 1'b0;
        while (expected_magnitudes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame_size(logic [CFG_DATA_BITS-1:0] width_data,
                                  logic [CFG_DATA_BITS-1:0] height_data);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_wdata <= width_data;
        @(posedge clk);
        cfg_index <= REG_IMAGE_HEIGHT;
        cfg_wdata <= height_data;
        @(posedge clk);
        cfg_we     <= 1'b0;
        width_reg  = width_data[WIDTH_BITS-1:0];
        height_reg = height_data;
    endtask

    // Width zero acts as one column; stray drain ticks while receiving are dropped.
    task automatic test_single_column();
        set_frame_size(16'd0, 16'd3);
        send_request(OP_DRAIN, 8'h00);
        send_request(OP_PIXEL, 8'h00);
        send_request(OP_PIXEL, 8'hFF);
        send_request(OP_PIXEL, 8'h00);
        send_request(OP_DRAIN, 8'hFF);
        send_request(OP_DRAIN, 8'h5A);
    endtask

    // Full-scale steps in both directions saturate; a pixel while draining is dropped.
    task automatic test_saturating_edges();
        set_frame_size(16'd3, 16'd2);
        send_request(OP_PIXEL, 8'h00);
        send_request(OP_PIXEL, 8'hFF);
        send_request(OP_PIXEL, 8'hFF);
        send_request(OP_PIXEL, 8'hFF);
        send_request(OP_PIXEL, 8'h00);
        send_request(OP_PIXEL, 8'h00);
        send_request(OP_DRAIN, 8'h00);
        send_request(OP_PIXEL, 8'hA5);
        send_request(OP_DRAIN, 8'h00);
        send_request(OP_DRAIN, 8'h00);
    endtask

    // Largest height, cut down between rows so that the next row ends the frame.
    task automatic test_height_cut_mid_frame();
        set_frame_size(16'd2, 16'hFFFF);
        repeat (4) send_request(OP_PIXEL, pick_pixel(NOISE_TEXTURE));
        set_frame_size(16'd2, 16'd2);
        repeat (2) send_request(OP_PIXEL, pick_pixel(NOISE_TEXTURE));
        repeat (2) send_request(OP_DRAIN, 8'h00);
    endtask

    // Width narrowed after the first row; the upper write-data bits are ignored.
    task automatic test_width_shrink_mid_frame();
        set_frame_size(16'd3, 16'd2);
        repeat (3) send_request(OP_PIXEL, pick_pixel(HARD_EDGES));
        set_frame_size({5'b10101, 11'd2}, 16'd2);
        repeat (2) send_request(OP_PIXEL, pick_pixel(HARD_EDGES));
        repeat (2) send_request(OP_DRAIN, 8'h00);
    endtask

    // Over-range width clamps to the line store size; height zero gives a
    // single-row frame whose every result comes from the drain.
    task automatic test_widest_single_row();
        set_frame_size(16'hFFFF, 16'd0);
        repeat (SEM_MAX_WIDTH) send_request(OP_PIXEL, pick_pixel(texture_t'($urandom_range(2))));
        repeat (SEM_MAX_WIDTH) send_request(OP_DRAIN, pixel_t'($urandom));
    endtask

    // Whole frames of random size and texture, with stray requests mixed in.
    task automatic test_random_frames(int item_goal);
        int          sent;
        int unsigned cols;
        int unsigned rows;
        int unsigned w_eff;
        int unsigned h_eff;
        int unsigned r;
        int unsigned c;
        texture_t    texture;
        sent = 0;
        while (sent < item_goal)
        begin
            cols    = ($urandom_range(9) == 0) ? $urandom_range(13, 48) : $urandom_range(0, 12);
            rows    = $urandom_range(0, 6);
            texture = texture_t'($urandom_range(2));
            set_frame_size({5'($urandom_range(31)), 11'(cols)}, 16'(rows));
            w_eff = active_columns();
            h_eff = active_rows();
            for (r = 0; r < h_eff; r++)
            begin
                for (c = 0; c < w_eff; c++)
                begin
                    if ($urandom_range(19) == 0) send_request(OP_DRAIN, pixel_t'($urandom));
                    send_request(OP_PIXEL, pick_pixel(texture));
                    sent++;
                end
            end
            for (c = 0; c < w_eff; c++)
            begin
                if ($urandom_range(19) == 0) send_request(OP_PIXEL, pick_pixel(texture));
                send_request(OP_DRAIN, pixel_t'($urandom));
                sent++;
            end
        end
    endtask

    // Takes results with random stalls and compares them with the oldest expectation.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (expected_magnitudes.size() == 0)
                begin
                    report_mismatch("unexpected result, magnitude", magnitude, -1);
                end
                else
                begin
                    want = expected_magnitudes.pop_front();
                    if (magnitude !== want.magnitude)
                        report_mismatch("magnitude", magnitude, want.magnitude);
                    if (last_in_run !== want.last_in_run)
                        report_mismatch("last_in_run", last_in_run, want.last_in_run);
                    if (end_of_frame !== want.end_of_frame)
                        report_mismatch("end_of_frame", end_of_frame, want.end_of_frame);
                end
                result_count++;
            end
            pop <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_magnitudes.size());
            $display("tb_sobel_edge_magnitude: FAIL");
            $finish;
        end
    end

    initial
    begin
        reset_predictor();
        send_idle_pct = 15;
        recv_idle_pct = 63;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_single_column();
        test_saturating_edges();
        test_height_cut_mid_frame();
        test_width_shrink_mid_frame();
        test_widest_single_row();
        test_random_frames(240);

        send_idle_pct = 63;
        recv_idle_pct = 15;
        test_random_frames(240);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_frames(240);

        wait_idle();
        if (error_count == 0 && expected_magnitudes.size() == 0)
        begin
            $display("tb_sobel_edge_magnitude: PASS");
        end
        else
        begin
            $display("tb_sobel_edge_magnitude: FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+src
src/sem_pkg.sv
src/sem_fifo.sv
src/sem_front.sv
src/sem_back.sv
src/sobel_edge_magnitude.sv
bench/tb_sobel_edge_magnitude.sv
